// ===== design/acalc_pkg.sv =====
// Shared types and constants for the ASCII decimal calculator.
package acalc_pkg;

    localparam int OPERAND_BITS = 32;
    // Decimal digits needed for the magnitude of an OPERAND_BITS-bit value
    localparam int NDIG   = (OPERAND_BITS * 30103) / 100000 + 1;
    localparam int BCD_W  = NDIG * 4;
    localparam int CNT_W  = $clog2(OPERAND_BITS);
    localparam int DCNT_W = $clog2(NDIG + 1);

    localparam int CMD_DEPTH = 2;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    typedef logic [OPERAND_BITS-1:0] t_operand;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_char;
        logic       out_last;
        logic       divide_by_zero;
    } t_out_item;

    typedef struct packed {
        logic [7:0] op;
        t_operand   a;
        t_operand   b;
    } t_cmd;

endpackage

// ===== design/acalc_front.sv =====
// Message parser: builds both operands and queues a command on the operator byte.
module acalc_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  acalc_pkg::t_in_item i_data,
    output logic               o_cmd_push,
    output acalc_pkg::t_cmd    o_cmd,
    input  logic               i_cmd_full
);
    import acalc_pkg::*;

    typedef enum logic [3:0] {
        F_FIRST  = 4'b0001,
        F_SECOND = 4'b0010,
        F_OP     = 4'b0100,
        F_SKIP   = 4'b1000
    } t_field;

    t_field   r_field, n_field;
    t_operand r_a, n_a;
    t_operand r_b, n_b;
    logic     w_acc;

    // acc*10 + (byte - 48), wrapping
    function automatic t_operand mac10(input t_operand acc, input logic [7:0] b);
        return (acc << 3) + (acc << 1) + t_operand'(b) - t_operand'(48);
    endfunction

    assign full  = (r_field == F_OP) && i_cmd_full;
    assign w_acc = push && !full;
    assign o_cmd = '{op: i_data.data_byte, a: r_a, b: r_b};

    always_comb begin
        n_field    = r_field;
        n_a        = r_a;
        n_b        = r_b;
        o_cmd_push = 1'b0;
        if (w_acc) begin
            case (r_field)
                F_FIRST: begin
                    if (i_data.data_byte == CH_COMMA) n_field = F_SECOND;
                    else n_a = mac10(r_a, i_data.data_byte);
                end
                F_SECOND: begin
                    if (i_data.data_byte == CH_COMMA) n_field = F_OP;
                    else n_b = mac10(r_b, i_data.data_byte);
                end
                F_OP: begin
                    o_cmd_push = 1'b1;
                    n_field    = F_SKIP;
                end
                F_SKIP: begin
                    n_field = F_SKIP;
                end
                default: begin
                    n_field = F_FIRST;
                end
            endcase
            if (i_data.end_of_message) begin
                n_a     = '0;
                n_b     = '0;
                n_field = F_FIRST;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field <= F_FIRST;
            r_a     <= '0;
            r_b     <= '0;
        end else begin
            r_field <= n_field;
            r_a     <= n_a;
            r_b     <= n_b;
        end
    end

endmodule

// ===== design/acalc_cmd_fifo.sv =====
// Short command queue between the parser and the execution unit.
module acalc_cmd_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  acalc_pkg::t_cmd i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output acalc_pkg::t_cmd o_cmd,
    output logic            o_empty
);
    import acalc_pkg::*;

    t_cmd                 r_mem [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [CMD_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CMD_PTR_W:0]   r_count, n_count;
    logic                 w_wr, w_rd;

    assign o_full  = (r_count == (CMD_PTR_W+1)'(CMD_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_wr) begin
            n_wr_ptr = (r_wr_ptr == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_rd) begin
            n_rd_ptr = (r_rd_ptr == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_wr && !w_rd) n_count = r_count + 1'b1;
        else if (!w_wr && w_rd) n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_wr_ptr] <= i_cmd;
    end

endmodule

// ===== design/acalc_back.sv =====
// Execution unit: shift-add multiply, restoring divide, binary-to-BCD, character emit.
module acalc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_empty,
    input  acalc_pkg::t_cmd     i_cmd,
    output logic                o_cmd_pop,
    output logic                empty,
    input  logic                pop,
    output acalc_pkg::t_out_item o_result
);
    import acalc_pkg::*;

    typedef enum logic [8:0] {
        B_IDLE  = 9'b000000001,
        B_MUL   = 9'b000000010,
        B_DIV   = 9'b000000100,
        B_PREP  = 9'b000001000,
        B_BCD   = 9'b000010000,
        B_SKIP  = 9'b000100000,
        B_SIGN  = 9'b001000000,
        B_DIGIT = 9'b010000000,
        B_DBZ   = 9'b100000000
    } t_state;

    t_state            r_state, n_state;
    t_operand          r_acc, n_acc;
    t_operand          r_x, n_x;
    t_operand          r_y, n_y;
    t_operand          r_res, n_res;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_direct, n_direct;
    logic              r_dneg, n_dneg;
    logic              r_neg, n_neg;
    logic [BCD_W-1:0]  r_bcd, n_bcd;
    logic [DCNT_W-1:0] r_dcnt, n_dcnt;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out, n_out;

    logic              w_out_free;
    t_operand          w_mul_acc;
    t_operand          w_rem_sh, w_rem_nx, w_q_nx;
    logic              w_ge;
    logic [BCD_W-1:0]  w_bcd_adj;
    logic [3:0]        w_top;

    function automatic t_operand mag(input t_operand v);
        return v[OPERAND_BITS-1] ? t_operand'(0) - v : v;
    endfunction

    assign w_out_free = !r_out_valid || pop;
    assign empty      = !r_out_valid;
    assign o_result   = r_out;
    assign w_top      = r_bcd[BCD_W-1 -: 4];

    // one multiply step
    assign w_mul_acc = r_acc + (r_y[0] ? r_x : '0);

    // one restoring divide step: r_acc remainder, r_y dividend/quotient, r_x divisor
    assign w_rem_sh = {r_acc[OPERAND_BITS-2:0], r_y[OPERAND_BITS-1]};
    assign w_ge     = (w_rem_sh >= r_x);
    assign w_rem_nx = w_ge ? w_rem_sh - r_x : w_rem_sh;
    assign w_q_nx   = {r_y[OPERAND_BITS-2:0], w_ge};

    // double-dabble digit correction
    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            w_bcd_adj[4*i +: 4] = (r_bcd[4*i +: 4] >= 4'd5) ?
                                  r_bcd[4*i +: 4] + 4'd3 : r_bcd[4*i +: 4];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_acc       = r_acc;
        n_x         = r_x;
        n_y         = r_y;
        n_res       = r_res;
        n_cnt       = r_cnt;
        n_direct    = r_direct;
        n_dneg      = r_dneg;
        n_neg       = r_neg;
        n_bcd       = r_bcd;
        n_dcnt      = r_dcnt;
        n_out       = r_out;
        n_out_valid = r_out_valid && !pop;
        o_cmd_pop   = 1'b0;

        case (r_state)
            B_IDLE: begin
                if (!i_cmd_empty) begin
                    o_cmd_pop = 1'b1;
                    n_direct  = 1'b0;
                    n_acc     = '0;
                    n_cnt     = CNT_W'(OPERAND_BITS - 1);
                    case (i_cmd.op)
                        CH_PLUS: begin
                            n_res   = i_cmd.a + i_cmd.b;
                            n_state = B_PREP;
                        end
                        CH_MINUS: begin
                            n_res   = i_cmd.a - i_cmd.b;
                            n_state = B_PREP;
                        end
                        CH_STAR: begin
                            n_x     = i_cmd.a;
                            n_y     = i_cmd.b;
                            n_state = B_MUL;
                        end
                        CH_SLASH: begin
                            if (i_cmd.b == '0) begin
                                n_state = B_DBZ;
                            end else begin
                                n_x     = mag(i_cmd.b);
                                n_y     = mag(i_cmd.a);
                                n_dneg  = i_cmd.a[OPERAND_BITS-1] ^ i_cmd.b[OPERAND_BITS-1];
                                n_state = B_DIV;
                            end
                        end
                        default: begin
                            n_res   = '0;
                            n_state = B_PREP;
                        end
                    endcase
                end
            end
            B_MUL: begin
                n_acc = w_mul_acc;
                n_x   = r_x << 1;
                n_y   = r_y >> 1;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_res   = w_mul_acc;
                    n_state = B_PREP;
                end
            end
            B_DIV: begin
                n_acc = w_rem_nx;
                n_y   = w_q_nx;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_res    = w_q_nx;
                    n_direct = 1'b1;
                    n_state  = B_PREP;
                end
            end
            B_PREP: begin
                // quotient is already the magnitude; its sign comes from the operands,
                // except that an unsigned 2^(N-1) quotient wraps negative
                if (r_direct) begin
                    n_neg = (r_res != '0) && (r_dneg || r_res[OPERAND_BITS-1]);
                    n_y   = r_res;
                end else begin
                    n_neg = r_res[OPERAND_BITS-1];
                    n_y   = mag(r_res);
                end
                n_bcd   = '0;
                n_cnt   = CNT_W'(OPERAND_BITS - 1);
                n_state = B_BCD;
            end
            B_BCD: begin
                n_bcd = {w_bcd_adj[BCD_W-2:0], r_y[OPERAND_BITS-1]};
                n_y   = r_y << 1;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_dcnt  = DCNT_W'(NDIG);
                    n_state = B_SKIP;
                end
            end
            B_SKIP: begin
                // drop leading zeros, keep at least one digit
                if (w_top == 4'd0 && r_dcnt != DCNT_W'(1)) begin
                    n_bcd  = r_bcd << 4;
                    n_dcnt = r_dcnt - 1'b1;
                end else begin
                    n_state = r_neg ? B_SIGN : B_DIGIT;
                end
            end
            B_SIGN: begin
                if (w_out_free) begin
                    n_out       = '{out_char: CH_MINUS, out_last: 1'b0, divide_by_zero: 1'b0};
                    n_out_valid = 1'b1;
                    n_state     = B_DIGIT;
                end
            end
            B_DIGIT: begin
                if (w_out_free) begin
                    n_out       = '{out_char: CH_ZERO + {4'd0, w_top},
                                    out_last: (r_dcnt == DCNT_W'(1)),
                                    divide_by_zero: 1'b0};
                    n_out_valid = 1'b1;
                    n_bcd       = r_bcd << 4;
                    n_dcnt      = r_dcnt - 1'b1;
                    if (r_dcnt == DCNT_W'(1)) n_state = B_IDLE;
                end
            end
            B_DBZ: begin
                if (w_out_free) begin
                    n_out       = '{out_char: CH_ZERO, out_last: 1'b1, divide_by_zero: 1'b1};
                    n_out_valid = 1'b1;
                    n_state     = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc    <= n_acc;
        r_x      <= n_x;
        r_y      <= n_y;
        r_res    <= n_res;
        r_cnt    <= n_cnt;
        r_direct <= n_direct;
        r_dneg   <= n_dneg;
        r_neg    <= n_neg;
        r_bcd    <= n_bcd;
        r_dcnt   <= n_dcnt;
        r_out    <= n_out;
    end

endmodule

// ===== design/ascii_decimal_calculator_top.sv =====
// Sequence: the operator byte queues a command; the back end computes + and - directly,
// runs * and / one bit per cycle, converts the result to BCD, drops leading zeros (up to
// NDIG - 1) and emits an optional sign and the digits; a divide by zero emits one flagged '0'.
// Throughput: one byte per cycle, except that an operator byte stalls while the 2-deep
// command queue is full; result characters wait in the output register until popped.
// Reset: synchronous active-low i_rst_n clears operands, parse state, queue and output.
module ascii_decimal_calculator_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input side (queue style)
    input  logic                 push,
    output logic                 full,
    input  acalc_pkg::t_in_item  i_data,
    // result side (queue style)
    output logic                 empty,
    input  logic                 pop,
    output acalc_pkg::t_out_item o_result
);
    import acalc_pkg::*;

    // front -> queue: one command transaction per operator byte
    logic w_cmd_push;
    t_cmd w_cmd_in;
    logic w_cmd_full;

    // queue -> back
    logic w_cmd_pop;
    t_cmd w_cmd_out;
    logic w_cmd_empty;

    // Parser: tracks the field, accumulates both operands, and emits {op, a, b}.
    // It only stalls the input side when an operator byte finds the queue full.
    acalc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_data     (i_data),
        .o_cmd_push (w_cmd_push),
        .o_cmd      (w_cmd_in),
        .i_cmd_full (w_cmd_full)
    );

    // Decouples parsing from the long execute/format sequence.
    acalc_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_cmd   (w_cmd_in),
        .o_full  (w_cmd_full),
        .i_pop   (w_cmd_pop),
        .o_cmd   (w_cmd_out),
        .o_empty (w_cmd_empty)
    );

    // Executes one command at a time and streams characters through a single
    // output register; a waiting character stalls only the back end, and the
    // parser keeps going until an operator byte finds the command queue full.
    acalc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (w_cmd_empty),
        .i_cmd       (w_cmd_out),
        .o_cmd_pop   (w_cmd_pop),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result)
    );

endmodule
